// File: hdl/lsfb_pkg.sv
// ============================================================================
// lsfb_pkg
// Shared constants and types for the linear seam feather blend pipeline.
// ============================================================================
package lsfb_pkg;

    // Field widths fixed by the pixel stream format
    localparam int COL_W       = 12;
    localparam int PIX_W       = 8;
    localparam int NCH         = 3;
    localparam int START_W     = 12;
    localparam int WIDTH_REG_W = 13;

    // Stream packing
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = NCH * PIX_W;
    localparam int BASE_LSB  = COL_W;
    localparam int OVER_LSB  = COL_W + NCH * PIX_W;

    // Default column limit
    localparam int MAX_WIDTH_DEF = 4096;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WIDTH_REG_W;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 1'b1;
    localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RST = 13'd4096;

    // Divider: 8 quotient bits, two bits per stage
    localparam int QUO_W          = PIX_W;
    localparam int DIV_STEPS      = 2;
    localparam int DIV_STAGES     = QUO_W / DIV_STEPS;

    // decode, multiply, sum, divider stages, output register
    localparam int PIPE_STAGES = 3 + DIV_STAGES + 1;

    typedef logic [NCH-1:0][PIX_W-1:0] t_pix3;

    // Data that rides alongside the arithmetic
    typedef struct packed {
        t_pix3 base;
        logic  ov;
        logic  copy;
    } t_side;

endpackage

// File: hdl/lsfb_div_stage.sv
// ============================================================================
// lsfb_div_stage
// Two restoring-division steps for all channels, registered on enable.
// ============================================================================
module lsfb_div_stage #(
    parameter int WW      = 13,
    parameter int STEP_HI = 7
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [lsfb_pkg::NCH-1:0][WW+lsfb_pkg::QUO_W-1:0] i_rem,
    input  logic [lsfb_pkg::NCH-1:0][lsfb_pkg::QUO_W-1:0]    i_q,
    input  logic [WW-1:0]                              i_span,
    output logic [lsfb_pkg::NCH-1:0][WW+lsfb_pkg::QUO_W-1:0] o_rem,
    output logic [lsfb_pkg::NCH-1:0][lsfb_pkg::QUO_W-1:0]    o_q,
    output logic [WW-1:0]                              o_span
);
    import lsfb_pkg::*;

    localparam int NW = WW + QUO_W;

    logic [NCH-1:0][NW-1:0]    n_rem;
    logic [NCH-1:0][QUO_W-1:0] n_q;

    always_comb begin
        logic [NW-1:0]    rem;
        logic [QUO_W-1:0] q;
        logic [NW-1:0]    dvs;
        for (int c = 0; c < NCH; c++) begin
            rem = i_rem[c];
            q   = i_q[c];
            for (int s = 0; s < DIV_STEPS; s++) begin
                dvs = NW'(i_span) << (STEP_HI - s);
                if (rem >= dvs) begin
                    rem = rem - dvs;
                    q   = q | (QUO_W'(1) << (STEP_HI - s));
                end
            end
            n_rem[c] = rem;
            n_q[c]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_q    <= n_q;
            o_span <= i_span;
        end
    end

endmodule

// File: hdl/linear_seam_feather_blend.sv
// ============================================================================
// linear_seam_feather_blend
// Linear feather blend of a warped overlay onto a base image across a seam.
// ============================================================================
// Streaming pixel blender, one pixel pair per clock while not stalled. Each
// slave-side transaction carries a column and two BGR pixels; each master-side
// transaction returns one pixel plus an overlap flag in tuser. Inside the
// overlap [overlap_start, min(image_width, MAX_WIDTH)) every channel becomes
// floor((base*(W-k) + over*k) / W) with W the overlap span and k the offset
// of the column into it; a pure black overlay copies the base pixel (flag
// still set), and columns outside the overlap pass the base pixel with the
// flag clear. The stages are decode, multiply, sum, four divider stages of
// two quotient bits each, and the output register. Throughput is one
// transaction per clock while the output does not stall; each stage holds
// its item only while the stage after it holds too, so bubbles are
// squeezed out and s_axis_tready can stay high while a result waits on
// m_axis_tready. Write the configuration registers only while no transaction
// is in flight; the config port is always ready.
// ============================================================================
module linear_seam_feather_blend #(
    parameter int MAX_WIDTH = lsfb_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [11:0] column, [19:12] base_ch0, [27:20] base_ch1, [35:28] base_ch2,
    // [43:36] over_ch0, [51:44] over_ch1, [59:52] over_ch2, [63:60] zero
    input  logic [lsfb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_ch0, [15:8] out_ch1, [23:16] out_ch2
    output logic [lsfb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] in_overlap
    output logic                            m_axis_tuser,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lsfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsfb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsfb_pkg::*;

    // Span width and numerator width follow from the column limit
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int NW = WW + QUO_W;
    localparam int CW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [START_W-1:0]     r_overlap_start;
    logic [WIDTH_REG_W-1:0] r_image_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap_start <= '0;
            r_image_width   <= IMAGE_WIDTH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OVERLAP_START: r_overlap_start <= i_cfg_data[START_W-1:0];
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid chain and per-stage load enables. A stage loads when it is
    // empty or when the stage after it loads too.
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] en;

    always_comb begin
        en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || m_axis_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < PIPE_STAGES; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: unpack, clamp width, classify the column
    // ------------------------------------------------------------------
    logic [COL_W-1:0] in_col;
    t_pix3            in_base;
    t_pix3            in_over;
    logic [CW-1:0]    col_x;
    logic [CW-1:0]    start_x;
    logic [CW-1:0]    width_x;
    logic             in_ov;

    always_comb begin
        in_col = s_axis_tdata[COL_W-1:0];
        for (int c = 0; c < NCH; c++) begin
            in_base[c] = s_axis_tdata[BASE_LSB + c*PIX_W +: PIX_W];
            in_over[c] = s_axis_tdata[OVER_LSB + c*PIX_W +: PIX_W];
        end
        col_x   = CW'(in_col);
        start_x = CW'(r_overlap_start);
        // saturate the width register at the column limit
        width_x = (CW'(r_image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                        : CW'(r_image_width);
        in_ov   = (col_x >= start_x) && (col_x < width_x);
    end

    t_side         r_s0_side;
    t_pix3         r_s0_over;
    logic [WW-1:0] r_s0_wk;
    logic [WW-1:0] r_s0_pos;
    logic [WW-1:0] r_s0_span;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_side.base <= in_base;
            r_s0_side.ov   <= in_ov;
            // outside the overlap or black overlay: take the base pixel
            r_s0_side.copy <= !in_ov || (in_over == '0);
            r_s0_over      <= in_over;
            // only meaningful inside the overlap, where none of the three exceeds W
            r_s0_wk        <= WW'(width_x - col_x);
            r_s0_pos       <= WW'(col_x - start_x);
            r_s0_span      <= WW'(width_x - start_x);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: weight products per channel
    // ------------------------------------------------------------------
    t_side                       r_s1_side;
    logic [NCH-1:0][NW-1:0]      r_s1_pb;
    logic [NCH-1:0][NW-1:0]      r_s1_po;
    logic [WW-1:0]               r_s1_span;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_side <= r_s0_side;
            r_s1_span <= r_s0_span;
            for (int c = 0; c < NCH; c++) begin
                r_s1_pb[c] <= NW'(r_s0_side.base[c]) * NW'(r_s0_wk);
                r_s1_po[c] <= NW'(r_s0_over[c]) * NW'(r_s0_pos);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerator, which stays below 256 * span
    // ------------------------------------------------------------------
    t_side                  r_s2_side;
    logic [NCH-1:0][NW-1:0] r_s2_num;
    logic [WW-1:0]          r_s2_span;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_side <= r_s1_side;
            r_s2_span <= r_s1_span;
            for (int c = 0; c < NCH; c++) begin
                r_s2_num[c] <= r_s1_pb[c] + r_s1_po[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 3..6: restoring divider, two quotient bits per stage
    // ------------------------------------------------------------------
    logic [DIV_STAGES:0][NCH-1:0][NW-1:0]    rem_chain;
    logic [DIV_STAGES:0][NCH-1:0][QUO_W-1:0] q_chain;
    logic [DIV_STAGES:0][WW-1:0]             span_chain;
    t_side                                   r_div_side [DIV_STAGES];

    assign rem_chain[0]  = r_s2_num;
    assign q_chain[0]    = '0;
    assign span_chain[0] = r_s2_span;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        lsfb_div_stage #(
            .WW      (WW),
            .STEP_HI (QUO_W - 1 - g*DIV_STEPS)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en[3+g]),
            .i_rem  (rem_chain[g]),
            .i_q    (q_chain[g]),
            .i_span (span_chain[g]),
            .o_rem  (rem_chain[g+1]),
            .o_q    (q_chain[g+1]),
            .o_span (span_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_div_side[0] <= r_s2_side;
        end
        for (int g = 1; g < DIV_STAGES; g++) begin
            if (en[3+g]) begin
                r_div_side[g] <= r_div_side[g-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: output register, select blend or base pixel
    // ------------------------------------------------------------------
    t_pix3 r_out_pix;
    logic  r_out_ov;

    always_ff @(posedge i_clk) begin
        if (en[PIPE_STAGES-1]) begin
            r_out_ov <= r_div_side[DIV_STAGES-1].ov;
            for (int c = 0; c < NCH; c++) begin
                r_out_pix[c] <= r_div_side[DIV_STAGES-1].copy
                              ? r_div_side[DIV_STAGES-1].base[c]
                              : q_chain[DIV_STAGES][c];
            end
        end
    end

    assign m_axis_tvalid = r_vld[PIPE_STAGES-1];
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tuser  = r_out_ov;

endmodule

// File: hdl/lsfb_checker.sv
// ============================================================================
// lsfb_checker
// Port-level checks on the feather blend pipeline, bound to the top level.
// ============================================================================
module lsfb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [lsfb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tuser
);
    import lsfb_pkg::*;

    localparam int CNT_W = $clog2(PIPE_STAGES + 1);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!in_acc && out_acc) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a result needs a transaction in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_cnt != '0))
        else $error("result shown with no transaction in flight");

    // never more in flight than the pipeline holds
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_STAGES))
        else $error("more transactions in flight than pipeline stages");

    // a free output lets the whole pipeline advance
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind linear_seam_feather_blend lsfb_checker u_lsfb_checker (.*);

// File: dv/tb_linear_seam_feather_blend.sv
// ============================================================================
// tb_linear_seam_feather_blend
// Self-checking testbench for the linear seam feather blender.
// ============================================================================
// A short table of directed pixel pairs comes first. It covers the field
// extremes, both edges of the overlap, a black overlay, an empty overlap, and
// a width register that saturates at the column limit. Random phases follow,
// each under its own blend setting. Every accepted input transaction
// predicts one output pixel, and each output transaction is compared with
// the oldest prediction. The sender works in bursts and the receiver stalls
// on its own pattern. Once the receiver also holds off long enough for the
// pipeline to fill and push back on the input.
// ============================================================================
module tb_linear_seam_feather_blend;
    timeunit 1ns;
    timeprecision 1ps;

    import lsfb_pkg::*;

    localparam int MAX_W       = MAX_WIDTH_DEF;
    localparam int LONG_HOLD   = 80;      // receiver hold-off, in cycles
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 96;
    localparam int SHOW_LIMIT  = 40;      // print at most this many mismatches

    typedef struct packed {
        logic [COL_W-1:0] column;
        t_pix3            base;
        t_pix3            over;
    } t_pixel_pair;

    typedef struct packed {
        t_pix3 pix;
        logic  in_overlap;
    } t_blend;

    typedef struct {
        int          start;
        int          width;
        t_pixel_pair px;
        bit          typed;     // want holds a typed-in answer
        t_blend      want;
    } t_seam_case;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Shadow copy of the blend setting the block holds
    logic [START_W-1:0]     cfg_start;
    logic [WIDTH_REG_W-1:0] cfg_width;

    t_blend     pending_pixels[$];
    t_seam_case seam_cases[$];
    int         mismatch_count = 0;
    int         pairs_sent;
    int         pixels_checked = 0;
    int         overlap_pixels = 0;
    int         settings_used;
    bit         long_hold_req;

    linear_seam_feather_blend #(
        .MAX_WIDTH(MAX_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes
    initial begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Append one row to the directed table
    task automatic add_case(input t_seam_case sc);
        seam_cases.insert(seam_cases.size(), sc);
    endtask

    // Expected output pixel for one pair under the current shadow setting.
    // The width register saturates at the column limit; the overlap is
    // [start, width), and a black overlay copies the base but keeps the flag.
    function automatic t_blend feathered_pixel(input t_pixel_pair p);
        t_blend      r;
        int unsigned eff_w;
        int unsigned span;
        int unsigned pos;
        int unsigned num;
        eff_w = (cfg_width > MAX_W) ? MAX_W : cfg_width;
        r.pix = p.base;
        r.in_overlap = 1'b0;
        if (p.column < cfg_start || p.column >= eff_w)
            return r;
        r.in_overlap = 1'b1;
        if (p.over != '0) begin
            span = eff_w - cfg_start;
            pos  = p.column - cfg_start;
            for (int c = 0; c < NCH; c++) begin
                num = p.base[c] * (span - pos) + p.over[c] * pos;
                r.pix[c] = PIX_W'(num / span);
            end
        end
        return r;
    endfunction

    function automatic t_seam_case mk_case(input int start, input int width, input int col,
                                           input logic [23:0] base, input logic [23:0] over,
                                           input int typed, input logic [23:0] want_pix,
                                           input int want_ov);
        t_seam_case sc;
        sc.start           = start;
        sc.width           = width;
        sc.px.column       = COL_W'(col);
        sc.px.base         = base;
        sc.px.over         = over;
        sc.typed           = (typed != 0);
        sc.want.pix        = want_pix;
        sc.want.in_overlap = (want_ov != 0);
        return sc;
    endfunction

    // Offer one pair at the current falling edge and hold it until accepted.
    // Return at the next falling edge with tvalid still high.
    task automatic send_pixel(input t_pixel_pair p, input bit typed, input t_blend want);
        s_axis_tdata  <= {{(S_TDATA_W - OVER_LSB - NCH * PIX_W){1'b0}},
                          p.over, p.base, p.column};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_pixels.insert(pending_pixels.size(), typed ? want : feathered_pixel(p));
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Drain the pipeline, then write both registers back to back.
    task automatic write_setting(input int start, input int width);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (PIPE_STAGES + 2) @(negedge i_clk);
        i_cfg_index <= CFG_OVERLAP_START;
        i_cfg_data  <= CFG_DATA_W'(start);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_start = START_W'(start);
        @(negedge i_clk);
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(width);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_width = WIDTH_REG_W'(width);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Receiver: rotate through stall patterns, and once hold off for a long
    // stretch when asked.
    initial begin : receiver
        int cyc;
        int mode;
        bit held;
        cyc  = 0;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                mode = (cyc / 256) % 4;
                cyc++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(1, 0));
                    2: m_axis_tready <= ($urandom_range(7, 0) != 0);
                    default: m_axis_tready <= ((cyc % 5) >= 2);
                endcase
            end
        end
    end

    // Check every output transaction against the oldest prediction
    always @(posedge i_clk) begin : pixel_check
        t_blend want;
        t_pix3  got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_pixels.size() == 0) begin
                flag_mismatch($sformatf("unexpected pixel %h flag %b", got, m_axis_tuser));
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (want.in_overlap)
                    overlap_pixels++;
                for (int c = 0; c < NCH; c++) begin
                    if (got[c] !== want.pix[c])
                        flag_mismatch($sformatf("out_ch%0d got %0d want %0d",
                                                c, got[c], want.pix[c]));
                end
                if (m_axis_tuser !== want.in_overlap)
                    flag_mismatch($sformatf("in_overlap got %b want %b",
                                            m_axis_tuser, want.in_overlap));
            end
        end
    end

    initial begin : stimulus
        t_pixel_pair p;
        t_blend      no_want;
        int          burst_left;
        int          gap;
        int          st;
        int          wd;
        int          eff_w;
        int          pick;
        bit          idle_on;

        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_OVERLAP_START;
        i_cfg_data     <= '0;
        cfg_start      = '0;
        cfg_width      = IMAGE_WIDTH_RST;
        pairs_sent     = 0;
        settings_used  = 0;
        long_hold_req  = 1'b0;
        no_want        = '0;

        // Directed cases; setting changes drain the pipeline first.
        // Reset setting: full-width overlap from column 0.
        add_case(mk_case(0, 4096, 0, 24'h1e140a, 24'h3264c8, 1, 24'h1e140a, 1));
        add_case(mk_case(0, 4096, 4095, 24'h000000, 24'hffffff, 1, 24'hfefefe, 1));
        add_case(mk_case(0, 4096, 100, 24'hffffff, 24'h000000, 1, 24'hffffff, 1));
        add_case(mk_case(0, 4096, 4095, 24'hffffff, 24'hffffff, 1, 24'hffffff, 1));
        add_case(mk_case(0, 4096, 2048, 24'h000000, 24'hffffff, 1, 24'h7f7f7f, 1));
        add_case(mk_case(0, 4096, 1, 24'h0000ff, 24'h000001, 0, 24'h0, 0));
        add_case(mk_case(0, 4096, 2048, 24'h804020, 24'h010000, 0, 24'h0, 0));
        // Narrow overlap: both edges, one column either side, black overlay
        add_case(mk_case(100, 200, 99, 24'habcdef, 24'h123456, 1, 24'habcdef, 0));
        add_case(mk_case(100, 200, 100, 24'habcdef, 24'h123456, 1, 24'habcdef, 1));
        add_case(mk_case(100, 200, 199, 24'habcdef, 24'h123456, 0, 24'h0, 0));
        add_case(mk_case(100, 200, 200, 24'habcdef, 24'h123456, 1, 24'habcdef, 0));
        add_case(mk_case(100, 200, 150, 24'h00ff80, 24'hff0080, 0, 24'h0, 0));
        add_case(mk_case(100, 200, 150, 24'h5a5a5a, 24'h000000, 1, 24'h5a5a5a, 1));
        // One-column overlap at the right edge
        add_case(mk_case(4095, 4096, 4095, 24'h55aa55, 24'haa55aa, 1, 24'h55aa55, 1));
        add_case(mk_case(4095, 4096, 4094, 24'h55aa55, 24'haa55aa, 1, 24'h55aa55, 0));
        // Width register past the limit saturates
        add_case(mk_case(0, 8191, 4095, 24'h000000, 24'hffffff, 1, 24'hfefefe, 1));
        add_case(mk_case(4095, 8191, 4095, 24'h123456, 24'h654321, 1, 24'h123456, 1));
        // Empty overlaps: start equal to or past the width, width zero
        add_case(mk_case(300, 300, 300, 24'h112233, 24'h445566, 1, 24'h112233, 0));
        add_case(mk_case(500, 200, 300, 24'h112233, 24'h445566, 1, 24'h112233, 0));
        add_case(mk_case(0, 0, 0, 24'h010203, 24'hffffff, 1, 24'h010203, 0));
        // Width one: only column 0 is inside
        add_case(mk_case(0, 1, 0, 24'h010203, 24'hffffff, 1, 24'h010203, 1));
        add_case(mk_case(0, 1, 1, 24'h010203, 24'hffffff, 1, 24'h010203, 0));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (seam_cases[i]) begin
            if (seam_cases[i].start != cfg_start || seam_cases[i].width != cfg_width)
                write_setting(seam_cases[i].start, seam_cases[i].width);
            send_pixel(seam_cases[i].px, seam_cases[i].typed, seam_cases[i].want);
        end

        // Random phases. The first three pin the setting extremes; phase 0
        // runs gap-free under the long receiver hold-off.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin st = 0;    wd = 8191; end
                1: begin st = 4095; wd = 4096; end
                2: begin st = 0;    wd = 1;    end
                default: begin
                    case ($urandom_range(4, 0))
                        0: begin
                            st = $urandom_range(4095, 0);
                            wd = $urandom_range(8191, 0);
                        end
                        1: begin
                            st = $urandom_range(255, 0);
                            wd = $urandom_range(8191, 4097);
                        end
                        2: begin
                            st = $urandom_range(4000, 0);
                            wd = st + $urandom_range(64, 1);
                        end
                        3: begin
                            wd = $urandom_range(4095, 0);
                            st = $urandom_range(4095, wd);
                        end
                        default: begin
                            st = $urandom_range(4095, 1024);
                            wd = 4096;
                        end
                    endcase
                end
            endcase
            write_setting(st, wd);
            if (ph == 0)
                long_hold_req = 1'b1;
            eff_w      = (wd > MAX_W) ? MAX_W : wd;
            idle_on    = (ph % 3 != 0);
            burst_left = $urandom_range(20, 1);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Column: mostly inside the overlap, some on its edges,
                // the rest anywhere in the row
                pick = $urandom_range(9, 0);
                if (eff_w > st && pick < 7) begin
                    p.column = COL_W'(st + $urandom_range(eff_w - st - 1, 0));
                end else if (pick < 8) begin
                    case ($urandom_range(3, 0))
                        0: p.column = COL_W'(st);
                        1: p.column = COL_W'(eff_w - 1);
                        2: p.column = COL_W'(st - 1);
                        default: p.column = COL_W'(eff_w);
                    endcase
                end else begin
                    p.column = COL_W'($urandom_range(4095, 0));
                end
                for (int c = 0; c < NCH; c++) begin
                    p.base[c] = ($urandom_range(15, 0) == 0) ?
                                PIX_W'($urandom_range(1, 0) * 255) : PIX_W'($urandom());
                end
                pick = $urandom_range(15, 0);
                for (int c = 0; c < NCH; c++) begin
                    if (pick < 2)
                        p.over[c] = '0;
                    else if (pick == 2)
                        p.over[c] = PIX_W'($urandom_range(1, 0) * 255);
                    else
                        p.over[c] = PIX_W'($urandom());
                end

                send_pixel(p, 1'b0, no_want);

                // Drop tvalid for a random gap at the end of each burst, unless the phase runs gap-free
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(20, 1);
                    if (idle_on) begin
                        gap = $urandom_range(6, 1);
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(negedge i_clk);
                    end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_STAGES + 4) @(posedge i_clk);

        $display("Covered %0d pixel pairs under %0d blend settings, one long output stall.",
                 pairs_sent, settings_used);
        $display("Checked %0d output pixels, %0d of them inside the overlap; %0d mismatches.",
                 pixels_checked, overlap_pixels, mismatch_count);
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/lsfb_pkg.sv
hdl/lsfb_div_stage.sv
hdl/linear_seam_feather_blend.sv
hdl/lsfb_checker.sv
dv/tb_linear_seam_feather_blend.sv
